/* rtl/base64_stream_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the base64 stream decoder
// Clocked assertions with reset gating; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define B64SD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge out of reset.
`define B64SD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define B64SD_ASSERT(lbl, clk, rst_n, prop, msg)
`define B64SD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/b64sd_pkg.sv */
// ----------------------------------------------------------------------------
// b64sd_pkg
// Types, character codes and helper functions for the base64 stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64sd_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
    localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
    localparam logic [5:0] SEXTET_PLUS       = 6'd62;
    localparam logic [5:0] SEXTET_SLASH      = 6'd63;

    localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

    typedef struct packed {
        logic       is_sextet;
        logic       is_pad;
        logic [5:0] value;
    } char_class_t;

    // One finished group waiting for serialization
    typedef struct packed {
        logic [23:0] bits;      // left-aligned group
        logic [1:0]  nbytes;    // bytes covered, 0-3
        logic        ends;      // group ends the data
        logic [15:0] base;      // byte total before this group
    } group_rec_t;

    function automatic char_class_t b64sd_classify(input logic [7:0] c);
        char_class_t r;
        r.is_sextet = 1'b1;
        r.is_pad    = 1'b0;
        r.value     = 6'd0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            r.value = 6'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            r.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
        end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
            r.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
        end else if (c == CHAR_PLUS) begin
            r.value = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            r.value = SEXTET_SLASH;
        end else if (c == CHAR_PAD) begin
            r.is_sextet = 1'b0;
            r.is_pad    = 1'b1;
        end else begin
            r.is_sextet = 1'b0;
        end
        return r;
    endfunction

    // Bytes covered by n sextets: (6 * n) / 8 for n up to four, zero above four
    function automatic logic [1:0] b64sd_byte_count(input logic [2:0] n);
        logic [1:0] r;
        case (n)
            3'd2:    r = 2'd1;
            3'd3:    r = 2'd2;
            3'd4:    r = 2'd3;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] b64sd_sat_inc(input logic [15:0] v);
        return (v == TOTAL_MAX) ? TOTAL_MAX : v + 16'd1;
    endfunction

endpackage

/* rtl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: one character in, decoded bytes out one per
// transaction, with end-of-data marking and a running byte count.
// ----------------------------------------------------------------------------
//
//  channel | dir | fields (tdata / tuser / tlast)
//  --------+-----+------------------------------------------------------------
//  s_*     | in  | tdata[7:0] char_code
//  m_*     | out | tdata[7:0] data_byte, [23:8] total_bytes; tuser[0] byte_valid; tlast last
//
//  One character is taken per cycle while s_tready is high; the group logic
//  runs in the same cycle as the accept and hands finished groups to a
//  two-entry queue. Results leave one per cycle from the output register
//  while m_tready is high, so a group of three bytes holds the output until
//  all three bytes are taken; ending characters right behind it can fill the
//  queue, and s_tready drops while both queue entries are held. Reset clears group state, queue and output valid.
//
`timescale 1ns / 1ps

`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder
    import b64sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [23:8] total_bytes
    output logic [0:0]  m_tuser,   // [0] byte_valid
    output logic        m_tlast
);

    // ------------------------------------------------------------------
    // Group assembly state
    // ------------------------------------------------------------------
    logic [23:0] group_bits_reg,  group_bits_next;
    logic [1:0]  group_pos_reg,   group_pos_next;
    logic [2:0]  sext_cnt_reg,    sext_cnt_next;
    logic [15:0] byte_total_reg,  byte_total_next;

    char_class_t cls;
    logic [23:0] bits_shift;
    logic [23:0] bits_aligned;
    logic [2:0]  cnt_inc;
    logic        in_take;
    logic        emit;
    group_rec_t  rec;
    logic [16:0] total_sum;

    // Queue of finished groups
    group_rec_t  fifo_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;
    logic        push;
    logic        pop;
    group_rec_t  head;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_bits_reg,  out_bits_next;
    logic [1:0]  out_rem_reg,   out_rem_next;   // results left in this group
    logic        out_ends_reg,  out_ends_next;
    logic        out_bv_reg,    out_bv_next;
    logic [15:0] out_tot_reg,   out_tot_next;
    logic        out_take;
    logic        need_load;

    assign s_tready = (count_reg != 2'd2);
    assign in_take  = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Character classification and group update
    // ------------------------------------------------------------------
    always_comb
    begin
        cls        = b64sd_classify(s_tdata);
        bits_shift = {group_bits_reg[17:0], (cls.is_pad ? 6'd0 : cls.value)};
        cnt_inc    = (cls.is_sextet && sext_cnt_reg != 3'd4) ? sext_cnt_reg + 3'd1
                                                             : sext_cnt_reg;

        // Cut-short group: left-align what has been shifted in so far
        case (group_pos_reg)
            2'd1:    bits_aligned = {group_bits_reg[5:0],  18'd0};
            2'd2:    bits_aligned = {group_bits_reg[11:0], 12'd0};
            2'd3:    bits_aligned = {group_bits_reg[17:0], 6'd0};
            default: bits_aligned = 24'd0;
        endcase

        emit        = 1'b0;
        rec.bits    = bits_shift;
        rec.nbytes  = b64sd_byte_count(cnt_inc);
        rec.ends    = (cnt_inc != 3'd4);
        rec.base    = byte_total_reg;
        if (!cls.is_sextet && !cls.is_pad) begin
            // terminating character: flush whatever the group holds
            emit       = 1'b1;
            rec.bits   = bits_aligned;
            rec.nbytes = b64sd_byte_count(sext_cnt_reg);
            rec.ends   = 1'b1;
        end else if (group_pos_reg == 2'd3) begin
            emit = 1'b1;
        end

        total_sum = {1'b0, byte_total_reg} + {15'd0, rec.nbytes};

        group_bits_next = group_bits_reg;
        group_pos_next  = group_pos_reg;
        sext_cnt_next   = sext_cnt_reg;
        byte_total_next = byte_total_reg;
        if (in_take) begin
            if (emit) begin
                group_bits_next = 24'd0;
                group_pos_next  = 2'd0;
                sext_cnt_next   = 3'd0;
                if (rec.ends) begin
                    byte_total_next = 16'd0;
                end else begin
                    byte_total_next = total_sum[16] ? TOTAL_MAX : total_sum[15:0];
                end
            end else begin
                group_bits_next = bits_shift;
                group_pos_next  = group_pos_reg + 2'd1;
                sext_cnt_next   = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            group_bits_reg <= 24'd0;
            group_pos_reg  <= 2'd0;
            sext_cnt_reg   <= 3'd0;
            byte_total_reg <= 16'd0;
        end else begin
            group_bits_reg <= group_bits_next;
            group_pos_reg  <= group_pos_next;
            sext_cnt_reg   <= sext_cnt_next;
            byte_total_reg <= byte_total_next;
        end
    end

    // ------------------------------------------------------------------
    // Group queue
    // ------------------------------------------------------------------
    assign push = in_take && emit;
    assign head = fifo_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= rec;
        end
    end

    // ------------------------------------------------------------------
    // Output serializer: at most one byte per transaction
    // ------------------------------------------------------------------
    assign out_take  = out_valid_reg && m_tready;
    assign need_load = !out_valid_reg || (out_take && out_rem_reg == 2'd1);
    assign pop       = need_load && (count_reg != 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};

        out_valid_next = out_valid_reg;
        out_bits_next  = out_bits_reg;
        out_rem_next   = out_rem_reg;
        out_ends_next  = out_ends_reg;
        out_bv_next    = out_bv_reg;
        out_tot_next   = out_tot_reg;

        if (pop) begin
            out_valid_next = 1'b1;
            out_ends_next  = head.ends;
            if (head.nbytes == 2'd0) begin
                // empty ending group: a single result with no byte
                out_bits_next = 24'd0;
                out_rem_next  = 2'd1;
                out_bv_next   = 1'b0;
                out_tot_next  = head.base;
            end else begin
                out_bits_next = head.bits;
                out_rem_next  = head.nbytes;
                out_bv_next   = 1'b1;
                out_tot_next  = b64sd_sat_inc(head.base);
            end
        end else if (need_load) begin
            out_valid_next = 1'b0;
        end else if (out_take) begin
            out_bits_next = {out_bits_reg[15:0], 8'd0};
            out_rem_next  = out_rem_reg - 2'd1;
            out_tot_next  = b64sd_sat_inc(out_tot_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            out_rem_reg   <= 2'd0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_rem_reg   <= out_rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_bits_reg <= out_bits_next;
        out_ends_reg <= out_ends_next;
        out_bv_reg   <= out_bv_next;
        out_tot_reg  <= out_tot_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tot_reg, out_bits_reg[23:16]};
    assign m_tuser  = out_bv_reg;
    assign m_tlast  = out_ends_reg && (out_rem_reg == 2'd1);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `B64SD_ASSERT_NEVER(a_queue_bound, clk, rst_n, count_reg == 2'd3,
        "group queue count out of range")
    `B64SD_ASSERT_NEVER(a_no_push_full, clk, rst_n, push && count_reg == 2'd2 && !pop,
        "group pushed into full queue")
    `B64SD_ASSERT(a_empty_is_last, clk, rst_n, (m_tvalid && !m_tuser[0]) |-> m_tlast,
        "result without a byte not marked last")
    `B64SD_ASSERT(a_cnt_le_pos, clk, rst_n, sext_cnt_reg <= {1'b0, group_pos_reg},
        "sextet count exceeds group position")
    `B64SD_ASSERT(a_rem_nonzero, clk, rst_n, m_tvalid |-> (out_rem_reg != 2'd0),
        "valid result with no remaining count")

endmodule
